[hdl/sps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

	// width of the prime count field
	localparam int COUNT_W = 17;
	// result word width, count padded to whole bytes
	localparam int OUT_W = ((COUNT_W + 7) / 8) * 8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQRT,
		ST_INIT,
		ST_BS_RD,
		ST_BS_CHK,
		ST_BS_MARK,
		ST_SG_RD,
		ST_SG_CHK,
		ST_SG_DIV,
		ST_SG_MARK,
		ST_CNT,
		ST_CNT_END,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

[hdl/segmented_prime_sieve_counter_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Segmented prime sieve counter.
// Input words (s_*) carry a query: lower_bound and upper_bound, both inclusive.
// Output words (m_*) carry the number of primes in that range and an error flag.
// A query is taken only while the core is idle (s_tready high); one result word
// comes back per query. An empty range, or one wider than SEGMENT_SIZE, returns
// at once with range_error set and a count of 0.
// A valid query runs in phases on two flag memories, one write and one read port each:
//   integer square root of upper_bound
//   fill both flag stores with "prime"
//   base sieve over [0, root]
//   segment marking, per base prime p: a division, then one write per multiple
//   count pass over the segment
// With the default sizes the marking loop, one memory write per cycle,
// dominates the run of a full 65536-wide segment.
// Reset clears the control state only; memory contents are rewritten by each
// query before they are read, so no clearing pass follows reset.
// A finished result sits in the output register; when the receiver stalls the
// core still accepts and works on the next query and waits at its end until
// the output register is free.
module segmented_prime_sieve_counter_core
	import sps_pkg::*;
#(
	parameter int UPPER_BITS   = 24,
	parameter int SEGMENT_SIZE = 65536,
	parameter int ROOT_SIZE    = 4097,
	localparam int IN_W = ((2 * UPPER_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // lower_bound, upper_bound, zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // prime_count, zero pad
	output logic             m_tuser   // range_error
);

	localparam int UB  = UPPER_BITS;
	localparam int SW  = $clog2(SEGMENT_SIZE);
	localparam int RW  = $clog2(ROOT_SIZE);
	localparam int QW  = (UB + 1) / 2;
	localparam int SCW = $clog2(QW + 1);
	localparam int KW  = (SW > RW) ? SW : RW;
	localparam int OW  = ((UB > KW) ? UB : KW) + 2;

	state_t state_q, state_d;

	// query registers
	logic [UB-1:0] lo_q;
	logic [SW-1:0] last_q;   // span - 1
	logic [RW-1:0] root_q;
	logic          err_q;

	// square root unit
	logic [2*QW-1:0] sx_q;
	logic [QW+1:0]   srem_q;
	logic [QW-1:0]   sroot_q;
	logic [SCW-1:0]  scnt_q;
	logic [QW+1:0]   srem_sh;
	logic [QW+1:0]   strial;
	logic            sge;

	// loop counters
	logic [RW:0]     i_q;
	logic [RW+1:0]   sq_q;
	logic [RW+1:0]   j_q;
	logic [KW-1:0]   k_q;
	logic [OW-1:0]   off_q;
	logic [COUNT_W-1:0] cnt_q;
	logic            rd_v_s1;
	logic [SW-1:0]   k_s1;

	// flag memories
	logic            base_mem [ROOT_SIZE];
	logic            seg_mem  [SEGMENT_SIZE];
	logic            base_rd_q;
	logic            seg_rd_q;
	logic            base_we;
	logic [RW-1:0]   base_wa;
	logic            base_wd;
	logic            seg_we;
	logic [SW-1:0]   seg_wa;
	logic            seg_wd;

	// divider
	logic            div_start;
	logic            div_done;
	logic            div_le1;
	logic [RW-1:0]   div_rem;

	// output register
	logic               m_tvalid_q;
	logic [COUNT_W-1:0] m_count_q;
	logic               m_err_q;
	logic               out_load;

	// input decode
	logic [UB-1:0] in_lo;
	logic [UB-1:0] in_hi;
	logic [UB:0]   in_diff;
	logic          in_err;

	logic          init_end;
	logic [OW-1:0] off_start;
	logic          num_ok;
	logic [RW+1:0] sq_next;

	assign in_lo   = s_tdata[UB-1:0];
	assign in_hi   = s_tdata[2*UB-1:UB];
	assign in_diff = (UB+1)'(in_hi) - (UB+1)'(in_lo);
	assign in_err  = in_diff[UB] || (64'(in_diff[UB-1:0]) >= 64'(SEGMENT_SIZE));

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'(m_count_q);
	assign m_tuser  = m_err_q;

	// one root bit per cycle
	assign srem_sh = {srem_q[QW-1:0], sx_q[2*QW-1:2*QW-2]};
	assign strial  = {sroot_q, 2'b01};
	assign sge     = srem_sh >= strial;

	assign init_end = (k_q >= KW'(root_q)) && (k_q >= KW'(last_q));
	assign sq_next  = sq_q + (RW+2)'({i_q, 1'b1});

	// first segment offset for base prime i
	always_comb begin
		if (div_le1) begin
			off_start = (OW'(i_q) << 1) - OW'(lo_q);
		end else if (div_rem != '0) begin
			off_start = OW'(i_q) - OW'(div_rem);
		end else begin
			off_start = '0;
		end
	end

	// numbers 0 and 1 are never counted
	assign num_ok = (|lo_q[UB-1:1]) || (lo_q[0] ? (k_s1 != '0) : (k_s1 > SW'(1)));

	sps_div #(
		.NW(UB),
		.DW(RW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (lo_q),
		.divisor  (i_q[RW-1:0]),
		.done     (div_done),
		.quot_le1 (div_le1),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		base_we   = 1'b0;
		base_wa   = k_q[RW-1:0];
		base_wd   = 1'b1;
		seg_we    = 1'b0;
		seg_wa    = k_q[SW-1:0];
		seg_wd    = 1'b1;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = in_err ? ST_DONE : ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (scnt_q == '0) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				base_we = (k_q <= KW'(root_q));
				seg_we  = (k_q <= KW'(last_q));
				if (init_end) begin
					state_d = ST_BS_RD;
				end
			end
			ST_BS_RD: begin
				state_d = (sq_q > (RW+2)'(root_q)) ? ST_SG_RD : ST_BS_CHK;
			end
			ST_BS_CHK: begin
				state_d = base_rd_q ? ST_BS_MARK : ST_BS_RD;
			end
			ST_BS_MARK: begin
				if (j_q <= (RW+2)'(root_q)) begin
					base_we = 1'b1;
					base_wa = j_q[RW-1:0];
					base_wd = 1'b0;
				end else begin
					state_d = ST_BS_RD;
				end
			end
			ST_SG_RD: begin
				state_d = (i_q > (RW+1)'(root_q)) ? ST_CNT : ST_SG_CHK;
			end
			ST_SG_CHK: begin
				if (base_rd_q) begin
					div_start = 1'b1;
					state_d   = ST_SG_DIV;
				end else begin
					state_d = ST_SG_RD;
				end
			end
			ST_SG_DIV: begin
				if (div_done) begin
					state_d = ST_SG_MARK;
				end
			end
			ST_SG_MARK: begin
				if (off_q <= OW'(last_q)) begin
					seg_we = 1'b1;
					seg_wa = off_q[SW-1:0];
					seg_wd = 1'b0;
				end else begin
					state_d = ST_SG_RD;
				end
			end
			ST_CNT: begin
				if (k_q == KW'(last_q)) begin
					state_d = ST_CNT_END;
				end
			end
			ST_CNT_END: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				lo_q    <= in_lo;
				last_q  <= SW'(in_diff[UB-1:0]);
				err_q   <= in_err;
				sx_q    <= (2*QW)'(in_hi);
				srem_q  <= '0;
				sroot_q <= '0;
				scnt_q  <= SCW'(QW);
			end
			ST_SQRT: begin
				if (scnt_q != '0) begin
					sx_q    <= sx_q << 2;
					srem_q  <= sge ? (srem_sh - strial) : srem_sh;
					sroot_q <= {sroot_q[QW-2:0], sge};
					scnt_q  <= scnt_q - SCW'(1);
				end else begin
					root_q <= (32'(sroot_q) > 32'(ROOT_SIZE - 1)) ? RW'(ROOT_SIZE - 1)
						: RW'(sroot_q);
					k_q    <= '0;
				end
			end
			ST_INIT: begin
				k_q  <= k_q + KW'(1);
				i_q  <= (RW+1)'(2);
				sq_q <= (RW+2)'(4);
			end
			ST_BS_RD: begin
				if (sq_q > (RW+2)'(root_q)) begin
					i_q <= (RW+1)'(2);
				end
			end
			ST_BS_CHK: begin
				j_q <= sq_q;
				if (!base_rd_q) begin
					i_q  <= i_q + (RW+1)'(1);
					sq_q <= sq_next;
				end
			end
			ST_BS_MARK: begin
				if (j_q <= (RW+2)'(root_q)) begin
					j_q <= j_q + (RW+2)'(i_q);
				end else begin
					i_q  <= i_q + (RW+1)'(1);
					sq_q <= sq_next;
				end
			end
			ST_SG_RD: begin
				k_q <= '0;
			end
			ST_SG_CHK: begin
				if (!base_rd_q) begin
					i_q <= i_q + (RW+1)'(1);
				end
			end
			ST_SG_DIV: begin
				off_q <= off_start;
			end
			ST_SG_MARK: begin
				if (off_q <= OW'(last_q)) begin
					off_q <= off_q + OW'(i_q);
				end else begin
					i_q <= i_q + (RW+1)'(1);
				end
			end
			ST_CNT: begin
				k_q <= k_q + KW'(1);
			end
			ST_CNT_END, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// count pass: read data arrives in the cycle after the address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			cnt_q   <= '0;
		end else begin
			rd_v_s1 <= (state_q == ST_CNT);
			if (state_q == ST_IDLE) begin
				cnt_q <= '0;
			end else if (rd_v_s1 && seg_rd_q && num_ok) begin
				cnt_q <= cnt_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= k_q[SW-1:0];
	end

	// base prime flags
	always_ff @(posedge clk) begin
		if (base_we) begin
			base_mem[base_wa] <= base_wd;
		end
		base_rd_q <= base_mem[i_q[RW-1:0]];
	end

	// segment flags
	always_ff @(posedge clk) begin
		if (seg_we) begin
			seg_mem[seg_wa] <= seg_wd;
		end
		seg_rd_q <= seg_mem[k_q[SW-1:0]];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_count_q <= cnt_q;
			m_err_q   <= err_q;
		end
	end

endmodule

`default_nettype wire

[hdl/sps_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module sps_div #(
	parameter int NW = 24,
	parameter int DW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic          quot_le1,
	output logic [DW-1:0] remainder
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsr_q;

	logic [DW:0]   trial;
	logic          ge;
	logic [DW-1:0] rem_n;

	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		ge    = trial >= {1'b0, dsr_q};
		rem_n = ge ? DW'(trial - {1'b0, dsr_q}) : DW'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= rem_n;
		end
	end

	assign done      = done_q;
	assign quot_le1  = (quo_q[NW-1:1] == '0);
	assign remainder = rem_q;

endmodule

`default_nettype wire

[tb/sps_count_checker.sv]
`timescale 1ns / 1ps

// Watches both stream channels of the sieve core, predicts the count for each
// accepted query and compares every returned word with the oldest prediction.
module sps_count_checker
	import sps_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [47:0]      s_tdata,   // lower_bound, upper_bound
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,   // prime_count, zero pad
	input  logic             m_tuser,   // range_error
	output int               fail_count,
	output int               outstanding,
	output int               queries_seen,
	output int               range_errors_seen
);

	localparam int BOUND_W      = 24;
	localparam int SEGMENT_SIZE = 65536;
	localparam int ROOT_SIZE    = 4097;

	typedef struct packed {
		logic [COUNT_W-1:0] prime_count;
		logic               range_error;
	} count_word_t;

	bit base_flags [0:ROOT_SIZE-1];
	bit seg_flags  [0:SEGMENT_SIZE-1];

	count_word_t expected_counts [$];
	int fails, queries, flagged;

	// integer square root, digit by digit
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned rem, res, pw;
		rem = v;
		res = 0;
		pw  = 64'd1 << 30;
		while (pw > v)
			pw = pw >> 2;
		while (pw != 0) begin
			if (rem >= res + pw) begin
				rem = rem - (res + pw);
				res = (res >> 1) + pw;
			end else begin
				res = res >> 1;
			end
			pw = pw >> 2;
		end
		return res;
	endfunction

	function automatic count_word_t predict_count(input logic [BOUND_W-1:0] lo_b,
			input logic [BOUND_W-1:0] hi_b);
		longint unsigned lo, hi, span, root, i, j, q, start, cnt;
		count_word_t w;
		lo = lo_b;
		hi = hi_b;
		w.prime_count = '0;
		w.range_error = 1'b1;
		// empty or wider than the segment: flagged, stores untouched
		if (hi < lo || hi - lo + 1 > SEGMENT_SIZE)
			return w;
		span = hi - lo + 1;
		root = int_sqrt(hi);
		if (root > ROOT_SIZE - 1)
			root = ROOT_SIZE - 1;
		for (i = 0; i <= root; i++)
			base_flags[i] = 1'b1;
		for (i = 0; i < span; i++)
			seg_flags[i] = 1'b1;
		for (i = 2; i * i <= root; i++) begin
			if (base_flags[i]) begin
				for (j = i * i; j <= root; j += i)
					base_flags[j] = 1'b0;
			end
		end
		for (i = 2; i <= root; i++) begin
			if (!base_flags[i])
				continue;
			q = lo / i;
			// low segment: the prime itself survives, start at its double
			if (q <= 1)
				start = 2 * i;
			else if (lo % i != 0)
				start = q * i + i;
			else
				start = q * i;
			for (j = start; j <= hi; j += i)
				seg_flags[j - lo] = 1'b0;
		end
		cnt = 0;
		for (i = 0; i < span; i++) begin
			if (seg_flags[i] && i + lo >= 2)
				cnt++;
		end
		w.prime_count = cnt[COUNT_W-1:0];
		w.range_error = 1'b0;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		count_word_t want;
		if (!arst_n) begin
			expected_counts.delete();
			fails   = 0;
			queries = 0;
			flagged = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (m_tuser)
					flagged++;
				if (expected_counts.size() == 0) begin
					$display("%0t: unexpected result word, count %0d error %0b",
						$time, m_tdata[COUNT_W-1:0], m_tuser);
					fails++;
				end else begin
					want = expected_counts.pop_front();
					if (m_tdata[COUNT_W-1:0] !== want.prime_count) begin
						$display("%0t: prime_count expected %0d actual %0d",
							$time, want.prime_count, m_tdata[COUNT_W-1:0]);
						fails++;
					end
					if (m_tuser !== want.range_error) begin
						$display("%0t: range_error expected %0b actual %0b",
							$time, want.range_error, m_tuser);
						fails++;
					end
					if (m_tdata[OUT_W-1:COUNT_W] !== '0) begin
						$display("%0t: pad bits expected 0 actual %0h",
							$time, m_tdata[OUT_W-1:COUNT_W]);
						fails++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				expected_counts.push_back(predict_count(s_tdata[23:0], s_tdata[47:24]));
				queries++;
			end
		end
		fail_count        <= fails;
		outstanding       <= expected_counts.size();
		queries_seen      <= queries;
		range_errors_seen <= flagged;
	end

endmodule

[tb/tb_segmented_prime_sieve_counter_core.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the segmented prime sieve core.
// The checker beside the core does all prediction and comparison; this module
// only produces query words, toggles backpressure and waits for the checker
// to drain before it gives the verdict.
module tb_segmented_prime_sieve_counter_core;
	import sps_pkg::*;

	localparam logic [23:0] MAXB = 24'hFFFFFF;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [47:0]      s_tdata;   // lower_bound, upper_bound
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;   // prime_count, zero pad
	logic             m_tuser;   // range_error

	int fail_count, outstanding, queries_seen, range_errors_seen;

	// idle rates in percent of cycles, changed per phase
	int send_idle_pct;
	int recv_idle_pct;

	segmented_prime_sieve_counter_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	sps_count_checker chk (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata),
		.m_tuser           (m_tuser),
		.fail_count        (fail_count),
		.outstanding       (outstanding),
		.queries_seen      (queries_seen),
		.range_errors_seen (range_errors_seen)
	);

	always #5 clk = ~clk;

	// receiver backpressure, redrawn every cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Present one query word and hold it until the core takes it.
	// Returns in the time step of the accepting edge.
	task automatic send_query(input logic [23:0] lo, input logic [23:0] hi);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {hi, lo};
		do @(posedge clk); while (!s_tready);
	endtask

	// Sender holds off until every predicted count has come back.
	// The first edge lets the checker register the last accepted word.
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Random queries. Most are well formed with small bounds so each one stays
	// cheap; a few place a short span anywhere in the 24-bit field (up to a full
	// base sieve), and the rest are raw noise or deliberately broken ranges.
	task automatic run_random(input int n);
		int          kind;
		int unsigned lo, hi, span;
		for (int k = 0; k < n; k++) begin
			kind = $urandom_range(99);
			if (kind < 15) begin
				lo = $urandom & MAXB;
				hi = $urandom & MAXB;
			end else if (kind < 25) begin
				if ($urandom_range(1) == 1) begin
					// empty range
					lo = $urandom_range(MAXB, 1);
					hi = $urandom_range(lo - 1, 0);
				end else begin
					// one past the segment or more
					lo = $urandom_range(MAXB - 65536, 0);
					hi = lo + 65536 + $urandom_range(4000);
					if (hi > MAXB)
						hi = MAXB;
				end
			end else if (kind < 33) begin
				lo = $urandom & MAXB;
				hi = lo + $urandom_range(511);
				if (hi > MAXB)
					hi = MAXB;
			end else begin
				hi = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(65535);
				span = $urandom_range(300);
				lo = (hi > span) ? hi - span : 0;
			end
			send_query(lo[23:0], hi[23:0]);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		send_idle_pct = 7;
		recv_idle_pct = 49;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: small ranges starting at zero, one and two
		send_query(24'd0, 24'd0);
		send_query(24'd0, 24'd1);
		send_query(24'd1, 24'd1);
		send_query(24'd2, 24'd2);
		send_query(24'd2, 24'd3);
		send_query(24'd0, 24'd100);
		// lower bound at or below twice a base prime
		send_query(24'd7, 24'd50);
		send_query(24'd4, 24'd30);
		// single prime square, upper bound a perfect square
		send_query(24'd49, 24'd49);
		send_query(24'd1000, 24'd1024);
		// empty ranges, including the widest inversion
		send_query(24'd5, 24'd4);
		send_query(MAXB, 24'd0);
		// one word wider than the segment, and the whole field
		send_query(24'd0, 24'd65536);
		send_query(24'd0, MAXB);
		// top of the bound field, and other large bounds
		send_query(MAXB, MAXB);
		send_query(MAXB - 24'd99, MAXB);
		send_query(24'd4000000, 24'd4000100);
		send_query(24'h555555, 24'h5555AA);
		send_query(24'hAAAAAA, 24'hAAAB00);
		send_query(24'h800000, 24'h8000C8);
		// widest legal segment, at the top of the range
		send_query(MAXB - 24'd65535, MAXB);
		drain();

		run_random(27);
		drain();

		send_idle_pct = 49;
		recv_idle_pct = 7;
		run_random(26);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(26);
		drain();

		repeat (20) @(posedge clk);
		$display("covered %0d queries, %0d of them flagged as range errors,",
			queries_seen, range_errors_seen);
		$display("directed edge cases then random queries under three idling profiles");
		if (fail_count == 0) begin
			$display("tb_segmented_prime_sieve_counter_core: clean");
		end else begin
			$display("tb_segmented_prime_sieve_counter_core: errors");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legitimate run
	initial begin
		#200_000_000;
		$display("watchdog expired with %0d results outstanding", outstanding);
		$display("tb_segmented_prime_sieve_counter_core: errors");
		$finish;
	end

endmodule

[segmented_prime_sieve_counter_core.f]
hdl/sps_pkg.sv
hdl/sps_div.sv
hdl/segmented_prime_sieve_counter_core.sv
tb/sps_count_checker.sv
tb/tb_segmented_prime_sieve_counter_core.sv
